// ----- hdl/zlcf_pkg.sv -----
// Shared types, widths, pipeline schedule and saturating helpers for the
// zip load curve fit block. Depends on nothing; every other file imports it.
package zlcf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 38;              // sign plus 37 magnitude bits
  localparam int MAG_W     = WIDE_W - 1;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int GAP_W     = WIDE_W + 1;
  localparam int GMAG_W    = GAP_W - 1;
  localparam int CFG_W     = 16;
  localparam int IDX_W     = 2;

  localparam logic [MAG_W-1:0] WIDE_MAX = '1;

  // divider: restoring, DIV_STEP quotient bits per stage
  localparam int DIV_NMAG_W = GAP_W - 1;
  localparam int DIV_DMAG_W = DIFF_W;
  localparam int DIV_DIVD_W = DIV_NMAG_W + FRAC_BITS + 1;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (MAG_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_QB     = DIV_STAGES * DIV_STEP;
  localparam int DIV_REM_W  = DIV_DMAG_W;
  localparam int DIV_LAT    = DIV_STAGES + 2;

  // multiplier: magnitude split into two partial products
  localparam int MUL_BMAG_W = DIFF_W;
  localparam int MUL_SPLIT  = (MAG_W + 1) / 2;
  localparam int MUL_PROD_W = MAG_W + MUL_BMAG_W + 1;
  localparam int MUL_LAT    = 3;

  // lane schedule, in register stages after acceptance
  localparam int ST_DIFF  = 1;
  localparam int ST_SLOPE = ST_DIFF + DIV_LAT;
  localparam int ST_GAP   = ST_SLOPE + 1;
  localparam int ST_LMUL  = ST_GAP + MUL_LAT;
  localparam int ST_CLIN  = ST_LMUL + 1;
  localparam int ST_SQ    = ST_GAP + DIV_LAT;
  localparam int ST_QMUL  = ST_SQ + MUL_LAT;
  localparam int ST_LIN   = ST_QMUL + 1;
  localparam int ST_T     = ST_LIN + 1;
  localparam int ST_TMUL  = ST_T + MUL_LAT;
  localparam int LANE_LAT = ST_TMUL + 1;

  localparam logic [1:0] LEVEL_CONST  = 2'd0;
  localparam logic [1:0] LEVEL_LINEAR = 2'd1;
  localparam logic [1:0] LEVEL_QUAD   = 2'd2;

  localparam logic [IDX_W-1:0] REG_DETAIL = 2'd0;
  localparam logic [IDX_W-1:0] REG_FORCE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_TOL    = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [GAP_W-1:0]  gap_t;

  typedef struct packed {
    data_t volt_a, real_a, react_a;
    data_t volt_b, real_b, react_b;
    data_t volt_c, real_c, react_c;
  } sample_t;

  typedef struct packed {
    data_t real_const, real_linear, real_square;
    data_t react_const, react_linear, react_square;
    logic  degenerate;
  } fit_t;

  typedef struct packed {
    logic [1:0]       detail_level;
    logic             force_linear;
    logic [CFG_W-1:0] linear_tolerance;
  } cfg_t;

  typedef struct packed {
    data_t volt_a, volt_b, volt_c;
    data_t pow_a, pow_b, pow_c;
  } lane_in_t;

  typedef struct packed {
    wide_t coef_const, coef_linear, coef_square;
    logic  ok;
  } lane_res_t;

  localparam gap_t  GAP_HI  = gap_t'({2'b00, WIDE_MAX});
  localparam gap_t  GAP_LO  = -GAP_HI;
  localparam wide_t DATA_HI = wide_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam wide_t DATA_LO = -DATA_HI - wide_t'(1);

  function automatic wide_t wide_sat(input gap_t x);
    wide_t r;
    if (x > GAP_HI) r = wide_t'(GAP_HI);
    else if (x < GAP_LO) r = wide_t'(GAP_LO);
    else r = wide_t'(x);
    return r;
  endfunction

  function automatic wide_t wide_add(input wide_t a, input wide_t b);
    return wide_sat(gap_t'(a) + gap_t'(b));
  endfunction

  function automatic wide_t wide_sub(input wide_t a, input wide_t b);
    return wide_sat(gap_t'(a) - gap_t'(b));
  endfunction

  function automatic wide_t ext_wide(input data_t d);
    return wide_t'(d);
  endfunction

  function automatic data_t sat32(input wide_t x);
    data_t r;
    if (x > DATA_HI) r = data_t'(DATA_HI);
    else if (x < DATA_LO) r = data_t'(DATA_LO);
    else r = data_t'(x);
    return r;
  endfunction

endpackage

// ----- hdl/zlcf_mul.sv -----
// Pipelined fixed point multiplier: wide operand times difference operand,
// rounded half away from zero and saturated. Depends on zlcf_pkg.
module zlcf_mul (
  input  logic            clk,
  input  logic            adv,
  input  zlcf_pkg::wide_t a,
  input  zlcf_pkg::diff_t b,
  output zlcf_pkg::wide_t prod
);
  import zlcf_pkg::*;

  localparam int PL_W  = MUL_SPLIT + MUL_BMAG_W;
  localparam int PH_W  = MAG_W - MUL_SPLIT + MUL_BMAG_W;
  localparam int RND_W = MUL_PROD_W - FRAC_BITS;
  localparam logic [MUL_PROD_W-1:0] HALF = MUL_PROD_W'(1) << (FRAC_BITS - 1);

  logic [MAG_W-1:0]      ua;
  logic [MUL_BMAG_W-1:0] ub;
  logic                  neg1, neg2;
  logic [PL_W-1:0]       pl;
  logic [PH_W-1:0]       ph;
  logic [MUL_PROD_W-1:0] full;
  logic [RND_W-1:0]      rnd;
  logic [MAG_W-1:0]      mag;

  always_comb begin
    full = (MUL_PROD_W'(ph) << MUL_SPLIT) + MUL_PROD_W'(pl) + HALF;
    rnd  = full[MUL_PROD_W-1:FRAC_BITS];
    mag  = (rnd > RND_W'(WIDE_MAX)) ? WIDE_MAX : rnd[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ua   <= a[WIDE_W-1] ? MAG_W'(-a) : MAG_W'(a);
      ub   <= b[DIFF_W-1] ? MUL_BMAG_W'(-b) : MUL_BMAG_W'(b);
      neg1 <= a[WIDE_W-1] ^ b[DIFF_W-1];
      pl   <= PL_W'(ua[MUL_SPLIT-1:0]) * PL_W'(ub);
      ph   <= PH_W'(ua[MAG_W-1:MUL_SPLIT]) * PH_W'(ub);
      neg2 <= neg1;
      prod <= neg2 ? -wide_t'({1'b0, mag}) : wide_t'({1'b0, mag});
    end
  end

endmodule

// ----- hdl/zlcf_div.sv -----
// Pipelined restoring divider: num * 2^FRAC_BITS / den, rounded half away
// from zero, saturated to the wide range. Depends on zlcf_pkg.
module zlcf_div (
  input  logic            clk,
  input  logic            adv,
  input  zlcf_pkg::gap_t  num,
  input  zlcf_pkg::diff_t den,
  output zlcf_pkg::wide_t quo
);
  import zlcf_pkg::*;

  typedef struct packed {
    logic [DIV_REM_W-1:0]  rem;
    logic [DIV_QB-1:0]     bits;   // dividend bits out the top, quotient in the bottom
    logic [DIV_DMAG_W-1:0] ud;
    logic                  neg;
    logic                  ovf;
  } div_stage_t;

  function automatic div_stage_t div_steps(input div_stage_t s_in);
    div_stage_t         s;
    logic [DIV_REM_W:0] trial;
    s = s_in;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {s.rem, s.bits[DIV_QB-1]};
      if (trial >= {1'b0, s.ud}) begin
        trial  = trial - {1'b0, s.ud};
        s.bits = {s.bits[DIV_QB-2:0], 1'b1};
      end else begin
        s.bits = {s.bits[DIV_QB-2:0], 1'b0};
      end
      s.rem = trial[DIV_REM_W-1:0];
    end
    return s;
  endfunction

  logic [DIV_NMAG_W-1:0] un;
  logic [DIV_DMAG_W-1:0] ud;
  logic [DIV_DIVD_W-1:0] dvd;
  div_stage_t            prep;
  div_stage_t            stage [0:DIV_STAGES];
  div_stage_t            stage_next [1:DIV_STAGES];
  logic [MAG_W-1:0]      mag;

  always_comb begin
    un = num[GAP_W-1] ? DIV_NMAG_W'(-num) : DIV_NMAG_W'(num);
    ud = den[DIFF_W-1] ? DIV_DMAG_W'(-den) : DIV_DMAG_W'(den);
    dvd = DIV_DIVD_W'({un, {FRAC_BITS{1'b0}}}) + DIV_DIVD_W'(ud >> 1);
    prep.rem  = DIV_REM_W'(dvd[DIV_DIVD_W-1:DIV_QB]);
    prep.bits = dvd[DIV_QB-1:0];
    prep.ud   = ud;
    prep.neg  = num[GAP_W-1] ^ den[DIFF_W-1];
    prep.ovf  = dvd[DIV_DIVD_W-1:MAG_W] >= ud;
    for (int s = 1; s <= DIV_STAGES; s++) stage_next[s] = div_steps(stage[s-1]);
    mag = stage[DIV_STAGES].ovf ? WIDE_MAX : stage[DIV_STAGES].bits[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage[0] <= prep;
      for (int s = 1; s <= DIV_STAGES; s++) stage[s] <= stage_next[s];
      quo <= stage[DIV_STAGES].neg ? -wide_t'({1'b0, mag}) : wide_t'({1'b0, mag});
    end
  end

endmodule

// ----- hdl/zlcf_lane.sv -----
// One fit lane: constant, linear or quadratic fit of one power curve.
// Depends on zlcf_pkg, zlcf_div and zlcf_mul.
module zlcf_lane (
  input  logic                clk,
  input  logic                adv,
  input  zlcf_pkg::cfg_t      cfg,
  input  zlcf_pkg::lane_in_t  din,
  output zlcf_pkg::lane_res_t res
);
  import zlcf_pkg::*;

  typedef struct packed {
    data_t v0;
    data_t p0;
    diff_t vsum;
    diff_t dab;
    diff_t dac;
    diff_t dbc;
    diff_t pab;
    diff_t pac;
    logic  dab_z;
    logic  dac_z;
    logic  dbc_z;
    wide_t sab;
    wide_t lin_sel;
    logic  is_lin;
    gap_t  gap;
    wide_t c0_lin;
    wide_t sq;
    wide_t lin;
    wide_t m2;
    wide_t tt;
  } ctx_t;

  ctx_t              ctx      [1:ST_TMUL];
  ctx_t              ctx_next [1:ST_TMUL];
  lane_res_t         res_next;
  wide_t             sab_w, sac_w, sq_w, mlin_w, m1_w, m2_w, mt_w;
  gap_t              sum, sum_adj, gap;
  logic [GMAG_W-1:0] gap_mag;
  ctx_t              fin;

  zlcf_div u_div_ab (.clk, .adv, .num(gap_t'(ctx[ST_DIFF].pab)), .den(ctx[ST_DIFF].dab),
                     .quo(sab_w));
  zlcf_div u_div_ac (.clk, .adv, .num(gap_t'(ctx[ST_DIFF].pac)), .den(ctx[ST_DIFF].dac),
                     .quo(sac_w));
  zlcf_div u_div_sq (.clk, .adv, .num(ctx[ST_GAP].gap), .den(ctx[ST_GAP].dbc), .quo(sq_w));

  zlcf_mul u_mul_lin (.clk, .adv, .a(ctx[ST_GAP].lin_sel), .b(diff_t'(ctx[ST_GAP].v0)),
                      .prod(mlin_w));
  zlcf_mul u_mul_m1 (.clk, .adv, .a(sq_w), .b(ctx[ST_SQ].vsum), .prod(m1_w));
  zlcf_mul u_mul_m2 (.clk, .adv, .a(sq_w), .b(diff_t'(ctx[ST_SQ].v0)), .prod(m2_w));
  zlcf_mul u_mul_t (.clk, .adv, .a(ctx[ST_T].tt), .b(diff_t'(ctx[ST_T].v0)), .prod(mt_w));

  always_comb begin
    ctx_next[1]       = '0;
    ctx_next[1].v0    = din.volt_a;
    ctx_next[1].p0    = din.pow_a;
    ctx_next[1].vsum  = diff_t'(din.volt_a) + diff_t'(din.volt_b);
    ctx_next[1].dab   = diff_t'(din.volt_b) - diff_t'(din.volt_a);
    ctx_next[1].dac   = diff_t'(din.volt_c) - diff_t'(din.volt_a);
    ctx_next[1].dbc   = diff_t'(din.volt_c) - diff_t'(din.volt_b);
    ctx_next[1].pab   = diff_t'(din.pow_b) - diff_t'(din.pow_a);
    ctx_next[1].pac   = diff_t'(din.pow_c) - diff_t'(din.pow_a);
    ctx_next[1].dab_z = din.volt_b == din.volt_a;
    ctx_next[1].dac_z = din.volt_c == din.volt_a;
    ctx_next[1].dbc_z = din.volt_c == din.volt_b;
    for (int k = 2; k <= ST_TMUL; k++) ctx_next[k] = ctx[k-1];

    // chord slopes: gap, truncated average, linearity test
    gap     = gap_t'(sac_w) - gap_t'(sab_w);
    sum     = gap_t'(sab_w) + gap_t'(sac_w);
    sum_adj = sum + gap_t'(sum[GAP_W-1]);
    gap_mag = gap[GAP_W-1] ? GMAG_W'(-gap) : GMAG_W'(gap);
    ctx_next[ST_GAP].sab     = sab_w;
    ctx_next[ST_GAP].gap     = gap;
    ctx_next[ST_GAP].is_lin  = cfg.force_linear ||
                               (gap_mag < GMAG_W'(cfg.linear_tolerance));
    ctx_next[ST_GAP].lin_sel = (cfg.detail_level == LEVEL_LINEAR) ? sab_w :
                               wide_t'(sum_adj >>> 1);

    ctx_next[ST_CLIN].c0_lin = wide_sub(ext_wide(ctx[ST_LMUL].p0), mlin_w);
    ctx_next[ST_SQ+1].sq     = sq_w;
    ctx_next[ST_LIN].lin     = wide_sub(ctx[ST_QMUL].sab, m1_w);
    ctx_next[ST_LIN].m2      = m2_w;
    ctx_next[ST_T].tt        = wide_add(ctx[ST_T-1].lin, ctx[ST_T-1].m2);

    fin = ctx[ST_TMUL];
    res_next.coef_const  = ext_wide(fin.p0);
    res_next.coef_linear = '0;
    res_next.coef_square = '0;
    res_next.ok          = 1'b1;
    if (cfg.detail_level != LEVEL_CONST) begin
      res_next.ok          = !fin.dab_z;
      res_next.coef_const  = fin.c0_lin;
      res_next.coef_linear = fin.lin_sel;
      if (cfg.detail_level != LEVEL_LINEAR) begin
        res_next.ok = !fin.dab_z && !fin.dac_z && (fin.is_lin || !fin.dbc_z);
        if (!fin.is_lin) begin
          res_next.coef_const  = wide_sub(ext_wide(fin.p0), mt_w);
          res_next.coef_linear = fin.lin;
          res_next.coef_square = fin.sq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= ST_TMUL; k++) ctx[k] <= ctx_next[k];
      res <= res_next;
    end
  end

endmodule

// ----- hdl/zip_load_curve_fit.sv -----
// Path: the difference stage loads on accept, then two 12-stage dividers and
// two 3-stage multipliers in series with the gap, linear and t add stages, and
// the output register. Real and reactive lanes run side by side.
// Throughput: one transaction per cycle while the skid register is empty.
// The output register plus skid register let one more result land while fit waits.
// Reset (rst, synchronous): clears the valid pipeline, output and skid flags, and
// loads detail_level 2, force_linear 0, linear_tolerance 7. No clearing pass.
module zip_load_curve_fit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  zlcf_pkg::sample_t             sample,
  output logic                          fit_valid,
  input  logic                          fit_ready,
  output zlcf_pkg::fit_t                fit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [zlcf_pkg::IDX_W-1:0]    cfg_index,
  input  logic [zlcf_pkg::CFG_W-1:0]    cfg_data
);
  import zlcf_pkg::*;

  cfg_t              cfg;
  lane_in_t          real_in, react_in;
  lane_res_t         real_res, react_res;
  logic [LANE_LAT:1] vld;
  logic              adv;
  logic              up_valid;
  logic              fit_ok;
  fit_t              merged;
  fit_t              fit_q, skid;
  logic              out_full, skid_valid;

  // Configuration: always ready, unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detail_level     <= LEVEL_QUAD;
      cfg.force_linear     <= 1'b0;
      cfg.linear_tolerance <= CFG_W'(7);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DETAIL: cfg.detail_level     <= cfg_data[1:0];
        REG_FORCE:  cfg.force_linear     <= cfg_data[0];
        REG_TOL:    cfg.linear_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the skid register holds a result.
  assign adv          = !skid_valid;
  assign sample_ready = adv;
  assign up_valid     = vld[LANE_LAT] && adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LANE_LAT-1:1], sample_valid};
  end

  // Split each sample into the real and reactive lanes.
  always_comb begin
    real_in.volt_a  = sample.volt_a;
    real_in.volt_b  = sample.volt_b;
    real_in.volt_c  = sample.volt_c;
    real_in.pow_a   = sample.real_a;
    real_in.pow_b   = sample.real_b;
    real_in.pow_c   = sample.real_c;
    react_in.volt_a = sample.volt_a;
    react_in.volt_b = sample.volt_b;
    react_in.volt_c = sample.volt_c;
    react_in.pow_a  = sample.react_a;
    react_in.pow_b  = sample.react_b;
    react_in.pow_c  = sample.react_c;
  end

  zlcf_lane u_lane_real (.clk, .adv, .cfg, .din(real_in), .res(real_res));
  zlcf_lane u_lane_react (.clk, .adv, .cfg, .din(react_in), .res(react_res));

  // Merge: a degenerate divisor in either lane zeroes all six coefficients.
  always_comb begin
    fit_ok              = real_res.ok && react_res.ok;
    merged.real_const   = fit_ok ? sat32(real_res.coef_const) : '0;
    merged.real_linear  = fit_ok ? sat32(real_res.coef_linear) : '0;
    merged.real_square  = fit_ok ? sat32(real_res.coef_square) : '0;
    merged.react_const  = fit_ok ? sat32(react_res.coef_const) : '0;
    merged.react_linear = fit_ok ? sat32(react_res.coef_linear) : '0;
    merged.react_square = fit_ok ? sat32(react_res.coef_square) : '0;
    merged.degenerate   = !fit_ok;
  end

  // Output register with skid: refill from skid first, else from the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_full || fit_ready) begin
      if (skid_valid) begin
        out_full   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_full <= up_valid;
      end
    end else if (up_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || fit_ready) begin
      if (skid_valid) fit_q <= skid;
      else if (up_valid) fit_q <= merged;
    end else if (up_valid) begin
      skid <= merged;
    end
  end

  assign fit_valid = out_full;
  assign fit       = fit_q;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_full)
    else $error("skid holds a result while the output register is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> vld[1])
    else $error("accepted transaction missing from the first pipeline stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while stalled");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (fit_valid && fit.degenerate) |->
      (fit.real_const == 0 && fit.real_linear == 0 && fit.real_square == 0 &&
       fit.react_const == 0 && fit.react_linear == 0 && fit.react_square == 0))
    else $error("degenerate fit with nonzero coefficients");

endmodule
